>>> hw/rtl/vehicle_hv_drive_mode_fsm_macros.svh
// Assertion macros for the HV drive mode block.
// Used by vehicle_hv_drive_mode_fsm.sv; needs no other file.
`ifndef VEHICLE_HV_DRIVE_MODE_FSM_MACROS_SVH
`define VEHICLE_HV_DRIVE_MODE_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define VHDM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VHDM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/vhdm_pkg.sv
// Shared types and constants for the HV drive mode block.
// No dependencies; used by vhdm_core and vehicle_hv_drive_mode_fsm.
`timescale 1ns / 1ps

package vhdm_pkg;

    // Operating modes, encoded as reported on the result beat
    typedef enum logic [2:0] {
        MODE_STANDBY   = 3'd0,
        MODE_PRECHARGE = 3'd1,
        MODE_HVON      = 3'd2,
        MODE_DRIVE     = 3'd3,
        MODE_NOTDRIVE  = 3'd4
    } mode_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_SC_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_READY_BRAKE     = 3'd1;
    localparam logic [2:0] CFG_RESUME_BRAKE    = 3'd2;
    localparam logic [2:0] CFG_REGEN_BRAKE     = 3'd3;
    localparam logic [2:0] CFG_REGEN_LEVEL     = 3'd4;
    localparam logic [2:0] CFG_PRECHARGE_TICKS = 3'd5;

    // Configuration reset values
    localparam logic [11:0] SC_THRESHOLD_RST    = 12'd600;
    localparam logic [6:0]  READY_BRAKE_RST     = 7'd10;
    localparam logic [6:0]  RESUME_BRAKE_RST    = 7'd10;
    localparam logic [6:0]  REGEN_BRAKE_RST     = 7'd40;
    localparam logic [10:0] REGEN_LEVEL_RST     = 11'd1613;
    localparam logic [15:0] PRECHARGE_TICKS_RST = 16'd3000;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [11:0] sc_threshold;
        logic [6:0]  ready_brake_threshold;
        logic [6:0]  resume_brake_threshold;
        logic [6:0]  regen_brake_threshold;
        logic [10:0] regen_level;
        logic [15:0] precharge_ticks;
    } cfg_t;

    typedef struct packed {
        logic        air_button;
        logic        ready_button;
        logic [11:0] sc_voltage;
        logic [6:0]  brake_percent;
        logic [6:0]  pedal_one_percent;
        logic [6:0]  pedal_two_percent;
        logic        pedals_plausible;
        logic        brake_plausible;
        logic [7:0]  torque_coefficient;
    } in_beat_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] precharge_count;
        logic        ready_flag;
        logic [15:0] held_torque;
        logic [10:0] held_regen;
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic        precharge_relay;
        logic        negative_relay;
        logic        positive_relay;
        logic        ready_to_drive;
        logic        sound_start;
        logic [15:0] torque_cmd;
        logic [10:0] regen_request;
    } result_t;

endpackage

>>> hw/rtl/vehicle_hv_drive_mode_fsm.sv
// Throughput: one beat per cycle while the result beat is drained (m_tready high);
// the input register feeds the mode update, which writes the result register
// and the machine state at the same edge.
// Reset (aresetn low, synchronous): standby, counters and requests zero,
// configuration registers back to their defaults, both channels empty.
// Depends on vhdm_pkg, vhdm_core and vehicle_hv_drive_mode_fsm_macros.svh.
`timescale 1ns / 1ps
`include "vehicle_hv_drive_mode_fsm_macros.svh"

module vehicle_hv_drive_mode_fsm (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sensor snapshot beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // air_button, ready_button, sc_voltage, brake_percent, pedal_one_percent,
    // pedal_two_percent, pedals_plausible, brake_plausible, torque_coefficient
    input  logic [vhdm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // mode, precharge_relay, negative_relay, positive_relay, ready_to_drive,
    // sound_start, torque_cmd, regen_request
    output logic [vhdm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [2:0]                         cfg_index,
    input  logic [vhdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    vhdm_pkg::cfg_t     cfg_reg;
    vhdm_pkg::state_t   state_reg;
    vhdm_pkg::state_t   state_next;
    vhdm_pkg::in_beat_t in_reg;
    vhdm_pkg::in_beat_t in_beat;
    vhdm_pkg::result_t  res_reg;
    vhdm_pkg::result_t  res_next;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    // Unpack the incoming beat
    always_comb begin
        in_beat.air_button         = s_tdata[0];
        in_beat.ready_button       = s_tdata[1];
        in_beat.sc_voltage         = s_tdata[13:2];
        in_beat.brake_percent      = s_tdata[20:14];
        in_beat.pedal_one_percent  = s_tdata[27:21];
        in_beat.pedal_two_percent  = s_tdata[34:28];
        in_beat.pedals_plausible   = s_tdata[35];
        in_beat.brake_plausible    = s_tdata[36];
        in_beat.torque_coefficient = s_tdata[44:37];
    end

    // Advance when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sc_threshold           <= vhdm_pkg::SC_THRESHOLD_RST;
            cfg_reg.ready_brake_threshold  <= vhdm_pkg::READY_BRAKE_RST;
            cfg_reg.resume_brake_threshold <= vhdm_pkg::RESUME_BRAKE_RST;
            cfg_reg.regen_brake_threshold  <= vhdm_pkg::REGEN_BRAKE_RST;
            cfg_reg.regen_level            <= vhdm_pkg::REGEN_LEVEL_RST;
            cfg_reg.precharge_ticks        <= vhdm_pkg::PRECHARGE_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                vhdm_pkg::CFG_SC_THRESHOLD:    cfg_reg.sc_threshold <= cfg_data[11:0];
                vhdm_pkg::CFG_READY_BRAKE:     cfg_reg.ready_brake_threshold <= cfg_data[6:0];
                vhdm_pkg::CFG_RESUME_BRAKE:    cfg_reg.resume_brake_threshold <= cfg_data[6:0];
                vhdm_pkg::CFG_REGEN_BRAKE:     cfg_reg.regen_brake_threshold <= cfg_data[6:0];
                vhdm_pkg::CFG_REGEN_LEVEL:     cfg_reg.regen_level <= cfg_data[10:0];
                vhdm_pkg::CFG_PRECHARGE_TICKS: cfg_reg.precharge_ticks <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the beat until it advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= in_beat;
        end
    end

    // Mode update
    vhdm_core u_core (
        .in_beat (in_reg),
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // Machine state: update once per advancing beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode            <= vhdm_pkg::MODE_STANDBY;
            state_reg.precharge_count <= '0;
            state_reg.ready_flag      <= 1'b0;
            state_reg.held_torque     <= '0;
            state_reg.held_regen      <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Pack the result beat
    assign m_tdata = {5'b0,
                      res_reg.regen_request,
                      res_reg.torque_cmd,
                      res_reg.sound_start,
                      res_reg.ready_to_drive,
                      res_reg.positive_relay,
                      res_reg.negative_relay,
                      res_reg.precharge_relay,
                      res_reg.mode};

    // Checks
    `VHDM_ASSERT_NOW(a_sound_in_drive, aclk, aresetn,
        out_valid_reg && res_reg.sound_start,
        (res_reg.mode == vhdm_pkg::MODE_DRIVE) && res_reg.ready_to_drive,
        "sound pulse outside drive entry")
    `VHDM_ASSERT_NOW(a_relay_exclusive, aclk, aresetn,
        out_valid_reg,
        !(res_reg.precharge_relay && res_reg.positive_relay),
        "precharge and positive relay closed together")
    `VHDM_ASSERT_NEXT(a_state_holds, aclk, aresetn,
        !advance,
        $stable(state_reg),
        "machine state moved without an advancing beat")
    `VHDM_ASSERT_NEXT(a_advance_fills, aclk, aresetn,
        advance,
        out_valid_reg,
        "advancing beat did not reach the result register")

endmodule

>>> hw/rtl/vhdm_core.sv
// Update of the drive mode machine for one beat: next state and result beat.
// Purely combinational; depends on vhdm_pkg.
`timescale 1ns / 1ps

module vhdm_core (
    input  vhdm_pkg::in_beat_t in_beat,
    input  vhdm_pkg::state_t   cur,
    input  vhdm_pkg::cfg_t     cfg,
    output vhdm_pkg::state_t   nxt,
    output vhdm_pkg::result_t  res
);

    logic        above;
    logic        below;
    logic        drive_ok;
    logic [15:0] count_inc;
    logic [7:0]  pedal_sum;
    logic [14:0] torque_prod;

    // Shared comparisons and datapath terms
    assign above       = in_beat.sc_voltage > cfg.sc_threshold;
    assign below       = in_beat.sc_voltage < cfg.sc_threshold;
    assign drive_ok    = above && cur.ready_flag && in_beat.pedals_plausible
                         && in_beat.brake_plausible;
    assign count_inc   = (cur.precharge_count == 16'hFFFF) ? cur.precharge_count
                                                           : cur.precharge_count + 16'd1;
    assign pedal_sum   = {1'b0, in_beat.pedal_one_percent}
                         + {1'b0, in_beat.pedal_two_percent};
    assign torque_prod = in_beat.torque_coefficient * pedal_sum[7:1];

    // Next state
    always_comb begin
        nxt = cur;
        case (cur.mode)
            vhdm_pkg::MODE_PRECHARGE: begin
                nxt.precharge_count = count_inc;
                if (count_inc >= cfg.precharge_ticks) begin
                    nxt.mode = vhdm_pkg::MODE_HVON;
                end
            end
            vhdm_pkg::MODE_HVON: begin
                if (above && (in_beat.brake_percent > cfg.ready_brake_threshold)
                        && in_beat.ready_button) begin
                    nxt.ready_flag = 1'b1;
                    nxt.mode       = vhdm_pkg::MODE_DRIVE;
                end
                if (below) begin
                    nxt.mode = vhdm_pkg::MODE_STANDBY;
                end
            end
            vhdm_pkg::MODE_DRIVE: begin
                if (drive_ok) begin
                    if (in_beat.brake_percent < cfg.regen_brake_threshold) begin
                        nxt.held_torque = {1'b0, torque_prod};
                        nxt.held_regen  = '0;
                    end else begin
                        nxt.held_torque = '0;
                        nxt.held_regen  = cfg.regen_level;
                    end
                end else begin
                    if (below) begin
                        nxt.mode = vhdm_pkg::MODE_STANDBY;
                    end
                    // pedal fault wins over undervoltage
                    if (!in_beat.pedals_plausible) begin
                        nxt.held_torque = '0;
                        nxt.mode        = vhdm_pkg::MODE_NOTDRIVE;
                    end
                end
            end
            vhdm_pkg::MODE_NOTDRIVE: begin
                if (below) begin
                    nxt.mode = vhdm_pkg::MODE_STANDBY;
                end
                if (in_beat.pedals_plausible
                        && (in_beat.brake_percent < cfg.resume_brake_threshold)) begin
                    nxt.ready_flag = 1'b1;
                    nxt.mode       = vhdm_pkg::MODE_DRIVE;
                end
            end
            default: begin
                nxt.ready_flag = 1'b0;
                nxt.mode       = vhdm_pkg::MODE_STANDBY;
                if (in_beat.air_button && above) begin
                    nxt.precharge_count = '0;
                    nxt.mode            = vhdm_pkg::MODE_PRECHARGE;
                end
            end
        endcase
    end

    // Outputs: relays follow the new mode, sound marks the HV-on to drive step
    always_comb begin
        res.mode            = nxt.mode;
        res.ready_to_drive  = nxt.ready_flag;
        res.torque_cmd      = nxt.held_torque;
        res.regen_request   = nxt.held_regen;
        res.sound_start     = (cur.mode == vhdm_pkg::MODE_HVON)
                              && (nxt.mode == vhdm_pkg::MODE_DRIVE);
        case (nxt.mode)
            vhdm_pkg::MODE_STANDBY: begin
                res.precharge_relay = 1'b0;
                res.negative_relay  = 1'b0;
                res.positive_relay  = 1'b0;
            end
            vhdm_pkg::MODE_PRECHARGE: begin
                res.precharge_relay = 1'b1;
                res.negative_relay  = 1'b1;
                res.positive_relay  = 1'b0;
            end
            default: begin
                res.precharge_relay = 1'b0;
                res.negative_relay  = 1'b1;
                res.positive_relay  = 1'b1;
            end
        endcase
    end

endmodule

>>> verif/tb.sv
// Testbench for the HV drive mode block: streams sensor snapshots, predicts
// every result beat and checks it. Depends on vhdm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import vhdm_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [2:0]             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicts the mode machine and holds the result beats still to arrive
    class drive_mode_scoreboard;
        logic [11:0] sc_thr;
        logic [6:0]  ready_brk;
        logic [6:0]  resume_brk;
        logic [6:0]  regen_brk;
        logic [10:0] regen_lvl;
        logic [15:0] pre_ticks;
        mode_t       mode;
        logic [15:0] pre_count;
        logic        ready_flag;
        logic [15:0] torque;
        logic [10:0] regen;
        result_t     pending_results[$];
        int          mismatches;
        int          results_seen;

        function new();
            sc_thr       = SC_THRESHOLD_RST;
            ready_brk    = READY_BRAKE_RST;
            resume_brk   = RESUME_BRAKE_RST;
            regen_brk    = REGEN_BRAKE_RST;
            regen_lvl    = REGEN_LEVEL_RST;
            pre_ticks    = PRECHARGE_TICKS_RST;
            mode         = MODE_STANDBY;
            pre_count    = '0;
            ready_flag   = 1'b0;
            torque       = '0;
            regen        = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_SC_THRESHOLD:    sc_thr = val[11:0];
                CFG_READY_BRAKE:     ready_brk = val[6:0];
                CFG_RESUME_BRAKE:    resume_brk = val[6:0];
                CFG_REGEN_BRAKE:     regen_brk = val[6:0];
                CFG_REGEN_LEVEL:     regen_lvl = val[10:0];
                CFG_PRECHARGE_TICKS: pre_ticks = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the machine by one accepted snapshot and queue its result
        function void note_snapshot(logic [IN_TDATA_W-1:0] d);
            logic        air, rdy, apps_ok, brake_ok, above, below, sound;
            logic [11:0] sc;
            logic [6:0]  brake, p1, p2;
            logic [7:0]  coef, pedal_avg;
            result_t     r;
            air       = d[0];
            rdy       = d[1];
            sc        = d[13:2];
            brake     = d[20:14];
            p1        = d[27:21];
            p2        = d[34:28];
            apps_ok   = d[35];
            brake_ok  = d[36];
            coef      = d[44:37];
            above     = sc > sc_thr;
            below     = sc < sc_thr;
            sound     = 1'b0;
            pedal_avg = ({1'b0, p1} + {1'b0, p2}) >> 1;

            case (mode)
                MODE_PRECHARGE: begin
                    if (pre_count != 16'hFFFF)
                        pre_count = pre_count + 16'd1;
                    if (pre_count >= pre_ticks)
                        mode = MODE_HVON;
                end
                MODE_HVON: begin
                    if (above && brake > ready_brk && rdy) begin
                        sound      = 1'b1;
                        ready_flag = 1'b1;
                        mode       = MODE_DRIVE;
                    end
                    if (below)
                        mode = MODE_STANDBY;
                end
                MODE_DRIVE: begin
                    if (above && ready_flag && apps_ok && brake_ok) begin
                        if (brake < regen_brk) begin
                            torque = {8'd0, coef} * {8'd0, pedal_avg};
                            regen  = '0;
                        end else begin
                            torque = '0;
                            regen  = regen_lvl;
                        end
                    end else begin
                        if (below)
                            mode = MODE_STANDBY;
                        // pedal fault wins over undervoltage
                        if (!apps_ok) begin
                            torque = '0;
                            mode   = MODE_NOTDRIVE;
                        end
                    end
                end
                MODE_NOTDRIVE: begin
                    if (below)
                        mode = MODE_STANDBY;
                    if (apps_ok && brake < resume_brk) begin
                        ready_flag = 1'b1;
                        mode       = MODE_DRIVE;
                    end
                end
                default: begin
                    ready_flag = 1'b0;
                    mode       = MODE_STANDBY;
                    if (air && above) begin
                        pre_count = '0;
                        mode      = MODE_PRECHARGE;
                    end
                end
            endcase

            r.mode            = mode;
            r.precharge_relay = (mode == MODE_PRECHARGE);
            r.negative_relay  = (mode != MODE_STANDBY);
            r.positive_relay  = (mode != MODE_STANDBY) && (mode != MODE_PRECHARGE);
            r.ready_to_drive  = ready_flag;
            r.sound_start     = sound;
            r.torque_cmd      = torque;
            r.regen_request   = regen;
            pending_results.push_back(r);
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_result(logic [OUT_TDATA_W-1:0] d);
            result_t got, want;
            got.mode            = mode_t'(d[2:0]);
            got.precharge_relay = d[3];
            got.negative_relay  = d[4];
            got.positive_relay  = d[5];
            got.ready_to_drive  = d[6];
            got.sound_start     = d[7];
            got.torque_cmd      = d[23:8];
            got.regen_request   = d[34:24];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %h with no expectation waiting", d);
                return;
            end
            want = pending_results.pop_front();
            if (got.mode !== want.mode ||
                got.precharge_relay !== want.precharge_relay ||
                got.negative_relay !== want.negative_relay ||
                got.positive_relay !== want.positive_relay ||
                got.ready_to_drive !== want.ready_to_drive ||
                got.sound_start !== want.sound_start ||
                got.torque_cmd !== want.torque_cmd ||
                got.regen_request !== want.regen_request) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch: mode %0d/%0d relays %b%b%b/%b%b%b",
                             results_seen, want.mode, got.mode,
                             want.precharge_relay, want.negative_relay, want.positive_relay,
                             got.precharge_relay, got.negative_relay, got.positive_relay);
                    $display("  ready %b/%b sound %b/%b torque %0d/%0d regen %0d/%0d",
                             want.ready_to_drive, got.ready_to_drive,
                             want.sound_start, got.sound_start,
                             want.torque_cmd, got.torque_cmd,
                             want.regen_request, got.regen_request);
                end
            end
        endfunction
    endclass

    drive_mode_scoreboard sb = new();
    int burst_left = 0;
    int idle_cycles = 0;

    vehicle_hv_drive_mode_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Pack one snapshot, first field in the lowest bits
    function automatic logic [IN_TDATA_W-1:0] pack_snapshot(
        logic air, logic rdy, logic [11:0] sc, logic [6:0] brake, logic [6:0] p1,
        logic [6:0] p2, logic apps_ok, logic brake_ok, logic [7:0] coef);
        return {3'b000, coef, brake_ok, apps_ok, p2, p1, brake, sc, rdy, air};
    endfunction

    // Mostly well-formed snapshots around the threshold, some pure noise
    function automatic logic [IN_TDATA_W-1:0] rand_snapshot(logic [11:0] thr);
        int          pick, t;
        logic [11:0] sc;
        logic [6:0]  brake;
        t = int'(thr);
        if ($urandom_range(0, 99) < 8)
            return pack_snapshot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 12'($urandom), 7'($urandom_range(0, 100)),
                                 7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            sc = (t == 0) ? 12'd0 : 12'($urandom_range(0, t - 1));
        else if (pick < 14)
            sc = thr;
        else if (pick < 20)
            sc = 12'($urandom);
        else
            sc = (t == 4095) ? thr : 12'($urandom_range(t + 1, 4095));
        brake = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 15))
                                            : 7'($urandom_range(0, 100));
        return pack_snapshot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sc, brake,
                             7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                             $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 90,
                             8'($urandom_range(0, 255)));
    endfunction

    // Offer one snapshot, with bursts and random gaps between them
    task automatic send_snapshot(input logic [IN_TDATA_W-1:0] beat);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        sb.note_snapshot(beat);
        burst_left--;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_snapshot(rand_snapshot(sb.sc_thr));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all six registers back to back while the block is idle
    task automatic configure(input logic [15:0] thr, input logic [15:0] ready_brk,
                             input logic [15:0] resume_brk, input logic [15:0] regen_brk,
                             input logic [15:0] regen_lvl, input logic [15:0] ticks);
        logic [2:0]  idx [6];
        logic [15:0] val [6];
        idx = '{CFG_SC_THRESHOLD, CFG_READY_BRAKE, CFG_RESUME_BRAKE,
                CFG_REGEN_BRAKE, CFG_REGEN_LEVEL, CFG_PRECHARGE_TICKS};
        val = '{thr, ready_brk, resume_brk, regen_brk, regen_lvl, ticks};
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result sink: own stall pattern plus one long hold-off
    initial begin : result_sink
        int seg_len, stall_pct;
        bit held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        forever begin
            if (!held_off && sb.results_seen >= 150) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            seg_len   = $urandom_range(1, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
            repeat (seg_len) begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Stop the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SC_THRESHOLD;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero precharge time, equal voltages, every mode exit
        configure(600, 10, 10, 40, 1613, 0);
        send_snapshot(pack_snapshot(1, 0, 600, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 1, 4095, 100, 100, 100, 1, 1, 255));
        send_snapshot(pack_snapshot(1, 0, 601, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_snapshot(pack_snapshot(0, 1, 600, 100, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 1, 4095, 10, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 100, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 1, 4095, 11, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 0, 100, 100, 1, 1, 255));
        send_snapshot(pack_snapshot(0, 0, 4095, 39, 1, 2, 1, 1, 7));
        send_snapshot(pack_snapshot(0, 0, 4095, 40, 50, 50, 1, 1, 255));
        send_snapshot(pack_snapshot(0, 0, 4095, 0, 100, 100, 1, 0, 255));
        send_snapshot(pack_snapshot(0, 0, 600, 0, 100, 100, 1, 1, 255));
        send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 0, 0, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 10, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 5, 100, 99, 1, 1, 200));
        send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(1, 1, 4095, 100, 100, 100, 1, 1, 255));
        send_snapshot(pack_snapshot(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_snapshot(pack_snapshot(0, 0, 599, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(1, 0, 4095, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 0, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 1, 4095, 100, 0, 0, 1, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 4095, 0, 0, 0, 0, 1, 0));
        send_snapshot(pack_snapshot(0, 0, 0, 50, 0, 0, 1, 1, 0));

        // Random phases across register settings, extremes included
        configure(600, 10, 10, 40, 1613, 5);
        send_random(450);
        configure(0, 0, 0, 0, 0, 1);
        send_random(200);
        configure(4095, 50, 50, 50, 777, 2);
        send_random(60);
        configure(2000, 20, 30, 45, 1200, 20);
        send_random(150);
        // Drain back to standby before the long precharge
        repeat (25) send_snapshot(pack_snapshot(0, 0, 0, 100, 0, 0, 1, 1, 0));
        configure(600, 100, 100, 100, 2047, 65535);
        send_snapshot(pack_snapshot(1, 0, 4095, 0, 0, 0, 1, 1, 0));
        send_random(40);
        // Shorten the precharge mid-count so the next tick completes it
        configure(600, 100, 100, 100, 2047, 1);
        send_random(150);
        configure(1500, 50, 30, 60, 1000, 12);
        send_random(400);
        configure(3000, 99, 0, 1, 2047, 3);
        send_random(250);
        configure(600, 10, 10, 40, 1613, 3000);
        send_random(100);

        // Drain and let the pipeline settle
        wait_idle();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/vhdm_pkg.sv
hw/rtl/vhdm_core.sv
hw/rtl/vehicle_hv_drive_mode_fsm.sv
verif/tb.sv
